>>> rtl/lsmt_pkg.sv
// Shared types and timing constants for the LCD scanline mode timer.
`default_nettype none
package lsmt_pkg;

   localparam int LINE_CYCLES_INT = 456;
   localparam int LAST_LINE_INT   = 153;

   localparam logic [9:0] LINE_CYCLES = 10'(LINE_CYCLES_INT);
   localparam logic [9:0] OAM_CYCLES  = 10'd80;
   localparam logic [9:0] XFER_CYCLES = 10'd172;
   localparam logic [9:0] OAM_BOUND   = 10'(LINE_CYCLES_INT - 80);
   localparam logic [9:0] XFER_BOUND  = 10'(LINE_CYCLES_INT - 80 - 172);
   localparam logic [7:0] VBLANK_LINE = 8'd144;
   localparam logic [7:0] LAST_LINE   = 8'(LAST_LINE_INT);

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [5:0] cycles;
      logic       display_on;
      logic [7:0] compare_line;
      logic       hblank_irq_en;
      logic       vblank_irq_en;
      logic       oam_irq_en;
      logic       match_irq_en;
   } req_data_type;

   typedef struct packed {
      mode_type   lcd_mode;
      logic [7:0] current_line;
      logic       line_match;
      logic       lcd_irq;
      logic       vblank_irq;
      logic       render_line;
   } rsp_data_type;

   typedef struct packed {
      logic [9:0] line_countdown;
      logic [7:0] line_counter;
      mode_type   mode;
      logic       match_flag;
   } timer_state_type;

endpackage
`default_nettype wire

>>> rtl/lsmt_if.sv
// Valid/ready channel interfaces for the request and response beats.
`default_nettype none
interface lsmt_req_if;
   import lsmt_pkg::*;
   logic         valid;
   logic         ready;
   req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lsmt_rsp_if;
   import lsmt_pkg::*;
   logic         valid;
   logic         ready;
   rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/lsmt_step.sv
// Next-state and result logic for one timer step.
`default_nettype none
module lsmt_step (
   input  wire lsmt_pkg::req_data_type    req_data,
   input  wire lsmt_pkg::timer_state_type state,
   output lsmt_pkg::timer_state_type      state_in,
   output lsmt_pkg::rsp_data_type         rsp_in
);
   import lsmt_pkg::*;

   mode_type   mode_new;
   logic       mode_int;
   logic       match_now;
   logic       expire;
   logic [7:0] line_next;

   always_comb begin
      mode_new  = MODE_HBLANK;
      mode_int  = 1'b0;
      match_now = (state.line_counter == req_data.compare_line);
      expire    = ({4'd0, req_data.cycles} >= state.line_countdown);
      line_next = state.line_counter + 8'd1;

      state_in = state;
      rsp_in   = '0;

      if (!req_data.display_on) begin
         // display off: restart the frame, keep the coincidence flag
         state_in.line_countdown = LINE_CYCLES;
         state_in.line_counter   = 8'd0;
         state_in.mode           = MODE_VBLANK;
      end else begin
         if (state.line_counter >= VBLANK_LINE) begin
            mode_new = MODE_VBLANK;
            mode_int = req_data.vblank_irq_en;
         end else if (state.line_countdown >= OAM_BOUND) begin
            mode_new = MODE_OAM;
            mode_int = req_data.oam_irq_en;
         end else if (state.line_countdown >= XFER_BOUND) begin
            mode_new = MODE_XFER;
         end else begin
            mode_new = MODE_HBLANK;
            mode_int = req_data.hblank_irq_en;
         end
         state_in.mode       = mode_new;
         state_in.match_flag = match_now;
         rsp_in.lcd_irq      = (mode_int && (mode_new != state.mode))
                               || (match_now && req_data.match_irq_en);

         if (expire) begin
            // reload without carry, advance the line
            state_in.line_countdown = LINE_CYCLES;
            if (line_next == VBLANK_LINE) begin
               rsp_in.vblank_irq = 1'b1;
            end else if (line_next > LAST_LINE) begin
               line_next = 8'd0;
            end
            state_in.line_counter = line_next;
            rsp_in.render_line    = (line_next < VBLANK_LINE);
         end else begin
            state_in.line_countdown = state.line_countdown - {4'd0, req_data.cycles};
         end
      end

      rsp_in.lcd_mode     = state_in.mode;
      rsp_in.current_line = state_in.line_counter;
      rsp_in.line_match   = state_in.match_flag;
   end
endmodule
`default_nettype wire

>>> rtl/lcd_scanline_mode_timer_core.sv
// Top level of the LCD scanline mode timer: state registers and response register.
//
// Usage: each request beat reports the machine cycles spent since the last
// beat, the display enable, the compare line and the four status interrupt
// enables. Every request beat yields exactly one response beat carrying the
// LCD mode, the current line, the coincidence flag and the LCD, vblank and
// render-line pulses for that step.
// Responses are registered: a beat accepted at an edge shows up on the
// response channel right after that edge. One beat is accepted per cycle while
// the receiver does not stall; the step logic is a handful of compares and one
// 10-bit subtract between the timer state registers and the response register.
// Reset puts the countdown at a full line, the line at 0, the mode at hblank
// and the coincidence flag low, and empties the response register.
// When the receiver stalls, the response register holds its beat and the
// request side keeps accepting only when that beat leaves in the same cycle.
`default_nettype none
module lcd_scanline_mode_timer_core (
   input  wire         clock,
   input  wire         reset,
   lsmt_req_if.sink    req_bus,
   lsmt_rsp_if.source  rsp_bus
);
   import lsmt_pkg::*;

   timer_state_type state_ff;
   timer_state_type state_in;
   rsp_data_type    rsp_data_ff;
   rsp_data_type    rsp_data_in;
   logic            rsp_valid_ff;
   logic            req_take;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;

   lsmt_step u_step (
      .req_data (req_bus.data),
      .state    (state_ff),
      .state_in (state_in),
      .rsp_in   (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.line_countdown <= LINE_CYCLES;
         state_ff.line_counter   <= 8'd0;
         state_ff.mode           <= MODE_HBLANK;
         state_ff.match_flag     <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            // drop the beat once taken
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;
endmodule
`default_nettype wire
